@@ rtl/idalloc_pkg.sv @@
// ----------------------------------------------------------------------------
// idalloc_pkg
// Shared constants for the ID allocator with its reuse stack.
// ----------------------------------------------------------------------------
package idalloc_pkg;

    localparam int MAX_FRESH_IDS = 1024;
    localparam int STACK_DEPTH   = 1024;

    localparam int STACK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FILL_W   = $clog2(STACK_DEPTH + 1);
    localparam int FRESH_W  = (MAX_FRESH_IDS > 1) ? $clog2(MAX_FRESH_IDS + 1) : 1;

    localparam int ID_W     = 32;
    localparam int DOMAIN_W = 8;
    localparam int LOCAL_W  = 24;

    localparam logic ACT_ALLOCATE = 1'b0;
    localparam logic ACT_RELEASE  = 1'b1;

    localparam logic [ID_W-1:0] ID_NONE = '1;

endpackage

@@ rtl/id_allocator_with_reuse_stack.sv @@
// ----------------------------------------------------------------------------
// id_allocator_with_reuse_stack
// Hands out 32-bit buffer IDs, reusing released IDs in LIFO order.
// ----------------------------------------------------------------------------
// The input channel carries one word per request: an allocate or a release.
// The output channel returns exactly one word for every accepted request.
// A release pushes its ID onto the reuse stack held in a RAM; if the stack is
// full the ID is dropped and release_dropped is set. An allocate pops the most
// recent released ID, or else forms a fresh ID from domain_id and a counter,
// or else returns all ones with granted low. The key words pass through on
// allocations and read as zero on releases.
// For releases and fresh allocations the result is registered at the
// accepting edge. A pop from the stack passes through ST_POP, set by the
// registered read port of the stack RAM; input stalls in ST_POP. A new word
// is accepted while the previous result is being taken. When the receiver
// stalls, the result register holds and the input stalls. Reset clears the
// fill count, the fresh counter and domain_id. The stack RAM is not cleared;
// only entries below the fill count are ever read. The user writes domain_id
// through cfg_we only while no request is in flight, which is not enforced.
// ----------------------------------------------------------------------------
module id_allocator_with_reuse_stack
    import idalloc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [DOMAIN_W-1:0] domain_id,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic [ID_W-1:0]     release_id,
    input  logic [31:0]         random_key_a,
    input  logic [31:0]         random_key_b,
    input  logic [31:0]         random_key_c,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                granted,
    output logic [ID_W-1:0]     given_id,
    output logic [31:0]         key_out_a,
    output logic [31:0]         key_out_b,
    output logic [31:0]         key_out_c,
    output logic                release_dropped
);

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    state_t              state_reg, state_next;
    logic [DOMAIN_W-1:0] domain_reg, domain_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FRESH_W-1:0]  fresh_reg, fresh_next;
    logic                out_valid_reg, out_valid_next;
    logic                granted_reg, granted_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [31:0]         key_a_reg, key_a_next;
    logic [31:0]         key_b_reg, key_b_next;
    logic [31:0]         key_c_reg, key_c_next;
    logic                dropped_reg, dropped_next;

    logic                in_accept;
    logic                stack_full;
    logic                stack_empty;
    logic                fresh_left;
    logic [FILL_W-1:0]   fill_dec;
    logic [FRESH_W+LOCAL_W-1:0] fresh_ext;
    logic                ram_we;
    logic [STACK_AW-1:0] ram_waddr;
    logic [STACK_AW-1:0] ram_raddr;
    logic [ID_W-1:0]     ram_rdata;

    assign in_stall    = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_accept   = in_valid && !in_stall;
    assign stack_full  = (fill_reg == FILL_W'(STACK_DEPTH));
    assign stack_empty = (fill_reg == '0);
    assign fresh_left  = (fresh_reg < FRESH_W'(MAX_FRESH_IDS));
    assign fill_dec    = fill_reg - FILL_W'(1);
    assign fresh_ext   = {{LOCAL_W{1'b0}}, fresh_reg};

    assign ram_we    = in_accept && (action == ACT_RELEASE) && !stack_full;
    assign ram_waddr = fill_reg[STACK_AW-1:0];
    assign ram_raddr = fill_dec[STACK_AW-1:0];

    idalloc_ram #(
        .WIDTH (ID_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (release_id),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        domain_next    = domain_reg;
        fill_next      = fill_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg && out_stall;
        granted_next   = granted_reg;
        id_next        = id_reg;
        key_a_next     = key_a_reg;
        key_b_next     = key_b_reg;
        key_c_next     = key_c_reg;
        dropped_next   = dropped_reg;

        if (cfg_we)
        begin
            domain_next = domain_id;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (action == ACT_RELEASE)
                    begin
                        out_valid_next = 1'b1;
                        granted_next   = 1'b0;
                        id_next        = ID_NONE;
                        key_a_next     = '0;
                        key_b_next     = '0;
                        key_c_next     = '0;
                        dropped_next   = stack_full;
                        if (!stack_full)
                        begin
                            fill_next = fill_reg + FILL_W'(1);
                        end
                    end
                    else
                    begin
                        key_a_next   = random_key_a;
                        key_b_next   = random_key_b;
                        key_c_next   = random_key_c;
                        dropped_next = 1'b0;
                        granted_next = 1'b1;
                        if (!stack_empty)
                        begin
                            fill_next  = fill_dec;
                            state_next = ST_POP;
                        end
                        else if (fresh_left)
                        begin
                            out_valid_next = 1'b1;
                            id_next        = {domain_reg, fresh_ext[LOCAL_W-1:0]};
                            fresh_next     = fresh_reg + FRESH_W'(1);
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            granted_next   = 1'b0;
                            id_next        = ID_NONE;
                        end
                    end
                end
            end
            ST_POP:
            begin
                out_valid_next = 1'b1;
                id_next        = ram_rdata;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            domain_reg    <= '0;
            fill_reg      <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
            granted_reg   <= 1'b0;
            id_reg        <= ID_NONE;
            key_a_reg     <= '0;
            key_b_reg     <= '0;
            key_c_reg     <= '0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            domain_reg    <= domain_next;
            fill_reg      <= fill_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
            granted_reg   <= granted_next;
            id_reg        <= id_next;
            key_a_reg     <= key_a_next;
            key_b_reg     <= key_b_next;
            key_c_reg     <= key_c_next;
            dropped_reg   <= dropped_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign granted         = granted_reg;
    assign given_id        = id_reg;
    assign key_out_a       = key_a_reg;
    assign key_out_b       = key_b_reg;
    assign key_out_c       = key_c_reg;
    assign release_dropped = dropped_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(STACK_DEPTH))
        else $error("Stack fill count exceeds the stack depth.");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= FRESH_W'(MAX_FRESH_IDS))
        else $error("Fresh counter exceeds its maximum.");

    a_pop_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && action == ACT_ALLOCATE && !stack_empty)
        |=> (state_reg == ST_POP) && !out_valid_reg ##1 out_valid_reg && granted_reg)
        else $error("Pop from the stack did not complete in two cycles.");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dropped_reg) |-> stack_full)
        else $error("Release was dropped while the stack was not full.");

endmodule

@@ rtl/idalloc_ram.sv @@
// ----------------------------------------------------------------------------
// idalloc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module idalloc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
